// ----- hdl/mdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mdp_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int POS_W        = $clog2(BLOCK_BYTES);
    localparam int WORD_BYTES   = 8;
    localparam int WORD_W       = 8 * WORD_BYTES;
    localparam int ASSEMBLY_W   = WORD_W - 8;
    localparam int LENGTH_BYTES = 8;
    localparam int LEN_IDX_W    = $clog2(LENGTH_BYTES);

    localparam logic [7:0]       PAD_MARK  = 8'h80;
    localparam logic [POS_W-1:0] LEN_START = POS_W'(BLOCK_BYTES - LENGTH_BYTES);

    localparam logic LEN_ORDER_MD5    = 1'b0;
    localparam logic LEN_ORDER_SHA256 = 1'b1;

    typedef struct packed {
        logic                word_done;
        logic                block_end;
        logic [POS_W-1:0]    position_next;
        logic [WORD_W-1:0]   word;
    } pk_result_t;

endpackage

`default_nettype wire

// ----- hdl/mdp_packer.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mdp_packer
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               clear,
    input  wire logic [7:0]         push_byte,
    output mdp_pkg::pk_result_t     result
);
    import mdp_pkg::*;

    logic [POS_W-1:0]      position_reg;
    logic [POS_W-1:0]      position_next;
    logic [ASSEMBLY_W-1:0] assembly_reg;
    logic [ASSEMBLY_W-1:0] assembly_next;
    logic [POS_W-1:0]      position_inc;
    logic [WORD_W-1:0]     word;
    logic                  word_done;

    assign position_inc = position_reg + POS_W'(1);
    assign word         = {assembly_reg, push_byte};
    assign word_done    = (position_inc[LEN_IDX_W-1:0] == '0);

    assign result.word_done     = word_done;
    assign result.block_end     = (position_inc == '0);
    assign result.position_next = position_inc;
    assign result.word          = word;

    always_comb
    begin
        position_next = position_reg;
        assembly_next = assembly_reg;
        if (clear)
        begin
            position_next = '0;
            assembly_next = '0;
        end
        else if (push)
        begin
            position_next = position_inc;
            assembly_next = word_done ? '0 : word[ASSEMBLY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            assembly_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
            assembly_reg <= assembly_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/md_hash_message_padder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Message padder for 64-byte-block hashes (MD5 / SHA-256). A byte-wide packer
// takes one byte per cycle, so message bytes stream at one transaction per
// cycle while the result register can accept. A transaction with message_end
// set starts padding: the packer then runs 0x80, the zero fill up to byte 56
// and the eight length bytes, one byte per cycle while the result register
// can accept, with in_ready low. length_order selects little-endian (0, MD5)
// or big-endian (1, SHA-256) length bytes; write it only while the block is
// idle.
module md_hash_message_padder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        message_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      block_word,
    output logic             block_done,
    output logic             padding_done
);
    import mdp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MARK = 4'b0010,
        S_ZERO = 4'b0100,
        S_LEN  = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 length_order_reg;
    logic [63:0]          bit_length_reg;
    logic [63:0]          bit_length_next;
    logic [LEN_IDX_W-1:0] len_idx_reg;
    logic [LEN_IDX_W-1:0] len_idx_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_W-1:0]    out_word_reg;
    logic                 out_block_reg;
    logic                 out_final_reg;

    logic                 slot_free;
    logic                 in_fire;
    logic                 push;
    logic                 clear;
    logic                 last_len;
    logic [7:0]           push_byte;
    logic [LEN_IDX_W-1:0] byte_sel;
    logic [7:0]           len_byte;
    pk_result_t           pk;

    mdp_packer u_packer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .clear     (clear),
        .push_byte (push_byte),
        .result    (pk)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;

    assign byte_sel  = (length_order_reg == LEN_ORDER_SHA256) ? ~len_idx_reg : len_idx_reg;
    assign len_byte  = bit_length_reg[{byte_sel, 3'b000} +: 8];
    assign last_len  = (state_reg == S_LEN) && slot_free && (len_idx_reg == '1);
    assign clear     = last_len;

    always_comb
    begin
        state_next      = state_reg;
        bit_length_next = bit_length_reg;
        len_idx_next    = len_idx_reg;
        push            = 1'b0;
        push_byte       = 8'h00;
        unique case (state_reg)
            S_IDLE:
            begin
                push_byte = data_byte;
                if (in_fire)
                begin
                    push = byte_present;
                    if (byte_present)
                        bit_length_next = bit_length_reg + 64'd8;
                    if (message_end)
                        state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                push_byte = PAD_MARK;
                push      = slot_free;
                if (slot_free)
                    state_next = (pk.position_next == LEN_START) ? S_LEN : S_ZERO;
            end
            S_ZERO:
            begin
                push = slot_free;
                if (slot_free && pk.position_next == LEN_START)
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                push_byte = len_byte;
                push      = slot_free;
                if (slot_free)
                begin
                    len_idx_next = len_idx_reg + LEN_IDX_W'(1);
                    if (last_len)
                    begin
                        state_next      = S_IDLE;
                        bit_length_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push && pk.word_done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            length_order_reg <= LEN_ORDER_MD5;
            bit_length_reg   <= '0;
            len_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_length_reg <= bit_length_next;
            len_idx_reg    <= len_idx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                length_order_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pk.word_done)
        begin
            out_word_reg  <= pk.word;
            out_block_reg <= pk.block_end;
            out_final_reg <= last_len;
        end
    end

    assign out_valid    = out_valid_reg;
    assign block_word   = out_word_reg;
    assign block_done   = out_block_reg;
    assign padding_done = out_final_reg;

    a_final_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        last_len |-> (push && pk.word_done && pk.block_end))
        else $error("final length byte does not close a block");

    a_len_index_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(state_reg == S_LEN)) |-> (len_idx_reg == '0))
        else $error("length sequence does not start at byte zero");

    a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        last_len |=> (state_reg == S_IDLE && bit_length_reg == '0))
        else $error("state not cleared after padding");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push && pk.word_done) |-> slot_free)
        else $error("result register overwritten while held");

endmodule

`default_nettype wire
